FILE: sv/assert_macros.svh
// Assertion helpers used by the engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define STHW_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, off while reset is high.
`define STHW_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

FILE: sv/sthw_pkg.sv
// ----------------------------------------------------------------------------
// sthw_pkg
// Types and codes shared by the tap-hold window judge.
// ----------------------------------------------------------------------------
package sthw_pkg;

   // event commands
   localparam logic [2:0] CMD_RECORD         = 3'd0;
   localparam logic [2:0] CMD_TICK           = 3'd1;
   localparam logic [2:0] CMD_JUDGE          = 3'd2;
   localparam logic [2:0] CMD_PEER           = 3'd3;
   localparam logic [2:0] CMD_RELATION_RESET = 3'd4;

   // window option bits
   localparam logic [2:0] OPT_HOKP  = 3'b001;
   localparam logic [2:0] OPT_PH    = 3'b010;
   localparam logic [2:0] OPT_RETRO = 3'b100;

   // register indexes
   localparam logic [1:0] REG_HOKP  = 2'd0;
   localparam logic [1:0] REG_PH    = 2'd1;
   localparam logic [1:0] REG_RETRO = 2'd2;

   localparam int unsigned CSR_AW = 4;

   typedef struct packed {
      logic        window;
      logic [7:0]  presses;
      logic [7:0]  releases;
      logic [31:0] press_stamp;
      logic [31:0] release_stamp;
   } act_rec_type;

   typedef struct packed {
      logic        hokp;
      logic        ph;
      logic        retro;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic        edge_flag;
      logic [15:0] key_pos;
      logic [31:0] event_ms;
      logic        is_tap_hold_key;
      logic [3:0]  taps_settled;
      logic        peer_window_flag;
      logic [7:0]  peer_presses;
      logic [7:0]  peer_releases;
      logic [31:0] peer_press_stamp;
      logic [31:0] peer_release_stamp;
   } req_beat_type;

   typedef struct packed {
      logic        hold_settled;
      logic        retro_cancel;
      logic        adv_changed;
      logic        adv_window;
      logic [7:0]  adv_presses;
      logic [7:0]  adv_releases;
      logic [31:0] adv_press_stamp;
      logic [31:0] adv_release_stamp;
   } rsp_beat_type;

endpackage

FILE: sv/sthw_csr.sv
// ----------------------------------------------------------------------------
// sthw_csr
// Option enable registers behind the APB-style port.
// ----------------------------------------------------------------------------
module sthw_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [sthw_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready,
   output sthw_pkg::cfg_type              cfg
);
   import sthw_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr;
   logic [1:0] idx;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[3:2];
   assign wr         = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            REG_HOKP:  cfg_in.hokp  = csr_pwdata[0];
            REG_PH:    cfg_in.ph    = csr_pwdata[0];
            REG_RETRO: cfg_in.retro = csr_pwdata[0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_HOKP:  csr_prdata = {31'd0, cfg_ff.hokp};
         REG_PH:    csr_prdata = {31'd0, cfg_ff.ph};
         REG_RETRO: csr_prdata = {31'd0, cfg_ff.retro};
         default:   csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: sv/sthw_engine.sv
// ----------------------------------------------------------------------------
// sthw_engine
// Window, counter and peer-image state with its single-pass update logic.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sthw_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  sthw_pkg::req_beat_type beat,
   input  sthw_pkg::cfg_type      cfg,
   output sthw_pkg::rsp_beat_type rsp
);
   import sthw_pkg::*;

   logic [7:0]  lp_ff, lp_in, lr_ff, lr_in;
   logic [31:0] lps_ff, lps_in, lrs_ff, lrs_in;
   logic        open_ff, open_in, retro_ff, retro_in;
   logic [15:0] key_ff, key_in;
   logic [31:0] ostamp_ff, ostamp_in;
   logic [2:0]  opt_ff, opt_in;
   logic        canc_ff, canc_in;
   logic [7:0]  snp_ff, snp_in, snr_ff, snr_in;
   act_rec_type adv_ff, adv_in, peer_ff, peer_in;
   logic        known_ff, known_in;

   act_rec_type adv_base, nxt, img;
   logic [2:0]  opts;
   logic        settle, cancel, changed, cmd_known;
   logic        p_in_win, r_in_win;

   function automatic logic not_before(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return !d[31];
   endfunction

   function automatic logic after(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return (d != 32'd0) && !d[31];
   endfunction

   assign img = '{window: beat.peer_window_flag, presses: beat.peer_presses,
                  releases: beat.peer_releases, press_stamp: beat.peer_press_stamp,
                  release_stamp: beat.peer_release_stamp};

   always_comb begin
      lp_in = lp_ff;     lr_in = lr_ff;     lps_in = lps_ff;   lrs_in = lrs_ff;
      open_in = open_ff; retro_in = retro_ff; key_in = key_ff; ostamp_in = ostamp_ff;
      opt_in = opt_ff;   canc_in = canc_ff; snp_in = snp_ff;   snr_in = snr_ff;
      peer_in = peer_ff; known_in = known_ff;
      adv_base = adv_ff;
      settle = 1'b0;
      cancel = 1'b0;
      opts = {cfg.retro, cfg.ph, cfg.hokp};
      p_in_win = known_ff && (peer_ff.presses != snp_ff)
                 && not_before(peer_ff.press_stamp, ostamp_ff);
      r_in_win = known_ff && (peer_ff.releases != snr_ff)
                 && not_before(peer_ff.release_stamp, ostamp_ff);
      cmd_known = 1'b1;
      case (beat.cmd)
         CMD_RECORD: begin
            if (beat.edge_flag) begin
               lp_in  = lp_ff + 8'd1;
               lps_in = beat.event_ms;
            end else begin
               lr_in  = lr_ff + 8'd1;
               lrs_in = beat.event_ms;
            end
            if (open_ff && beat.key_pos == key_ff && beat.is_tap_hold_key) begin
               if (beat.edge_flag && beat.taps_settled == 4'd0) begin
                  if (!retro_ff) begin
                     if ((opt_ff & OPT_RETRO) != 3'd0 && !canc_ff) begin
                        retro_in = 1'b1;
                     end else begin
                        open_in  = 1'b0;
                        retro_in = 1'b0;
                     end
                  end
               end else if (beat.edge_flag || retro_ff) begin
                  open_in  = 1'b0;
                  retro_in = 1'b0;
               end
            end
         end
         CMD_TICK: begin
            if (beat.edge_flag) begin
               if (!(open_ff && beat.key_pos == key_ff && !retro_ff)) begin
                  open_in  = 1'b0;
                  retro_in = 1'b0;
                  if (opts != 3'd0) begin
                     open_in   = 1'b1;
                     key_in    = beat.key_pos;
                     ostamp_in = beat.event_ms;
                     opt_in    = opts;
                     canc_in   = 1'b0;
                     snp_in    = peer_ff.presses;
                     snr_in    = peer_ff.releases;
                  end
               end
            end else if (open_ff && !retro_ff) begin
               open_in  = 1'b0;
               retro_in = 1'b0;
            end
         end
         CMD_JUDGE: begin
            if (open_ff && !retro_ff && p_in_win
                && !(beat.edge_flag && after(peer_ff.press_stamp, beat.event_ms))) begin
               if ((opt_ff & OPT_HOKP) != 3'd0) begin
                  settle = 1'b1;
               end else if ((opt_ff & OPT_PH) != 3'd0 && r_in_win
                  && !(beat.edge_flag && after(peer_ff.release_stamp, beat.event_ms))) begin
                  settle = 1'b1;
               end
               if ((opt_ff & OPT_RETRO) != 3'd0 && !canc_ff) begin
                  canc_in = 1'b1;
                  cancel  = 1'b1;
               end
            end
         end
         CMD_PEER: begin
            if (!(known_ff && peer_ff == img)) begin
               peer_in  = img;
               known_in = 1'b1;
               if (open_ff) begin
                  // stale activity (before the window opened) moves the snapshot
                  if (!not_before(img.press_stamp, ostamp_ff)) snp_in = img.presses;
                  if (!not_before(img.release_stamp, ostamp_ff)) snr_in = img.releases;
               end
               if (open_ff && retro_ff && (opt_ff & OPT_RETRO) != 3'd0 && !canc_ff
                   && img.presses != snp_in && not_before(img.press_stamp, ostamp_ff)) begin
                  canc_in = 1'b1;
                  cancel  = 1'b1;
               end
            end
         end
         CMD_RELATION_RESET: begin
            known_in = 1'b0;
            peer_in  = '0;
            adv_base = '0;
         end
         default: begin
            cmd_known = 1'b0;
         end
      endcase

      nxt = adv_base;
      nxt.window = open_in;
      if (known_in && peer_in.window) begin
         nxt.presses       = lp_in;
         nxt.releases      = lr_in;
         nxt.press_stamp   = lps_in;
         nxt.release_stamp = lrs_in;
      end
      // a relation reset clears the record first, so compare against the cleared base
      changed = cmd_known && (nxt != adv_base);
      adv_in  = cmd_known ? nxt : adv_ff;
   end

   assign rsp = '{hold_settled: settle, retro_cancel: cancel, adv_changed: changed,
                  adv_window: adv_in.window, adv_presses: adv_in.presses,
                  adv_releases: adv_in.releases, adv_press_stamp: adv_in.press_stamp,
                  adv_release_stamp: adv_in.release_stamp};

   always_ff @(posedge clock) begin
      if (reset) begin
         lp_ff <= '0;     lr_ff <= '0;     lps_ff <= '0;    lrs_ff <= '0;
         open_ff <= 1'b0; retro_ff <= 1'b0; key_ff <= '0;   ostamp_ff <= '0;
         opt_ff <= '0;    canc_ff <= 1'b0; snp_ff <= '0;    snr_ff <= '0;
         adv_ff <= '0;    peer_ff <= '0;   known_ff <= 1'b0;
      end else if (fire) begin
         lp_ff <= lp_in;     lr_ff <= lr_in;     lps_ff <= lps_in;  lrs_ff <= lrs_in;
         open_ff <= open_in; retro_ff <= retro_in; key_ff <= key_in; ostamp_ff <= ostamp_in;
         opt_ff <= opt_in;   canc_ff <= canc_in; snp_ff <= snp_in;  snr_ff <= snr_in;
         adv_ff <= adv_in;   peer_ff <= peer_in; known_ff <= known_in;
      end
   end

   `STHW_ASSERT_IMP(a_retro_needs_window, clock, reset, retro_ff, open_ff)
   `STHW_ASSERT_NXT(a_cancel_sticks, clock, reset, fire && rsp.retro_cancel, canc_ff)
   `STHW_ASSERT_IMP(a_settle_only_judge, clock, reset, rsp.hold_settled,
                    beat.cmd == CMD_JUDGE)
   `STHW_ASSERT_IMP(a_adv_window_tracks, clock, reset, 1'b1, adv_ff.window == open_ff)

endmodule

FILE: sv/split_tap_hold_window_judge.sv
// ----------------------------------------------------------------------------
// split_tap_hold_window_judge
// Tap-hold judgment window tracker for one half of a split keyboard.
//
//   channel  dir  handshake             beat
//   req      in   req_valid/req_stall   sthw_pkg::req_beat_type
//   rsp      out  rsp_valid/rsp_stall   sthw_pkg::rsp_beat_type
//   csr      in   APB-style, pready=1   option enables, 3 x 1 bit
//
// One beat per cycle sustained while rsp_stall is low; a beat passes the input
// register, then the state update writes the result register. The window
// state loop closes within the engine. Synchronous reset clears the valid
// flags, engine and option state, not the beat registers; no clearing pass.
// req_stall rises only when both registers are full and the result is stalled.
// ----------------------------------------------------------------------------
module split_tap_hold_window_judge (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  sthw_pkg::req_beat_type         req_beat,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output sthw_pkg::rsp_beat_type         rsp_beat,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [sthw_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   import sthw_pkg::*;

   cfg_type      cfg;
   logic         in_valid_ff, in_valid_in;
   req_beat_type in_beat_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_beat_type out_beat_ff, result;
   logic         accept, advance;

   sthw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sthw_engine u_engine (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .beat  (in_beat_ff),
      .cfg   (cfg),
      .rsp   (result)
   );

   assign advance      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign accept       = req_valid && !req_stall;
   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_beat_ff <= req_beat;
      end
      if (advance) begin
         out_beat_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_beat  = out_beat_ff;

endmodule

FILE: bench/split_tap_hold_window_judge_tb.sv
// ----------------------------------------------------------------------------
// split_tap_hold_window_judge_tb
// Self-checking bench for the split-keyboard tap-hold window judge. A queue of
// event beats feeds a clocked driver. Each accepted beat runs through a local
// model of the window, counter and peer-image state, and the model's report is
// queued. A clocked monitor compares each report beat field by field with the
// oldest queued one. Phases step through every option setting and several
// idle/stall mixes, with one long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module split_tap_hold_window_judge_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sthw_pkg::*;

   localparam logic [2:0] CMD_UNKNOWN_FIRST = 3'd5;
   localparam logic [2:0] CMD_UNKNOWN_LAST  = 3'd7;
   localparam int PHASE_ITEMS     = 190;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 6;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic         req_valid = 1'b0;
   logic         req_stall;
   req_beat_type req_beat  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_beat_type rsp_beat;

   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr   = '0;
   logic [31:0]         csr_pwdata  = '0;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   split_tap_hold_window_judge u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_beat    (req_beat),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_beat    (rsp_beat),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   req_beat_type pending_events[$];
   rsp_beat_type expected_reports[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   logic want_hold_off = 1'b0;
   logic hold_off_done = 1'b0;
   int hold_off_left = 0;

   // option enables as last written
   cfg_type csr_shadow = '0;

   // window tracker state
   logic [7:0]  cnt_press = '0, cnt_release = '0;
   logic [31:0] stamp_press = '0, stamp_release = '0;
   logic        w_open = 1'b0, w_retro = 1'b0, w_cancelled = 1'b0;
   logic [15:0] w_key = '0;
   logic [31:0] w_stamp = '0;
   logic [2:0]  w_opts = '0;
   logic [7:0]  snap_press = '0, snap_release = '0;
   act_rec_type adv_rec = '0, peer_rec = '0;
   logic        peer_seen = 1'b0;

   // stimulus generator state
   logic [31:0] gen_ms = '0;
   act_rec_type gen_peer = '0;

   function automatic logic not_before(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return !d[31];
   endfunction

   function automatic logic later_than(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d != 32'd0 && !d[31];
   endfunction

   function automatic logic peer_press_seen();
      return peer_seen && peer_rec.presses != snap_press &&
             not_before(peer_rec.press_stamp, w_stamp);
   endfunction

   function automatic logic peer_release_seen();
      return peer_seen && peer_rec.releases != snap_release &&
             not_before(peer_rec.release_stamp, w_stamp);
   endfunction

   function automatic void close_window();
      w_open  = 1'b0;
      w_retro = 1'b0;
   endfunction

   // recompose the advertised record; counters only follow an open peer window
   function automatic logic publish_adv();
      act_rec_type nxt;
      logic diff;
      nxt = adv_rec;
      nxt.window = w_open;
      if (peer_seen && peer_rec.window) begin
         nxt.presses       = cnt_press;
         nxt.releases      = cnt_release;
         nxt.press_stamp   = stamp_press;
         nxt.release_stamp = stamp_release;
      end
      diff = (nxt != adv_rec);
      adv_rec = nxt;
      return diff;
   endfunction

   function automatic rsp_beat_type judge_event(req_beat_type b);
      rsp_beat_type r;
      act_rec_type img;
      logic [2:0] opts;
      logic settle, cancel, changed;
      settle = 1'b0;
      cancel = 1'b0;
      changed = 1'b0;
      case (b.cmd)
         CMD_RECORD: begin
            if (b.edge_flag) begin
               cnt_press = cnt_press + 8'd1;
               stamp_press = b.event_ms;
            end else begin
               cnt_release = cnt_release + 8'd1;
               stamp_release = b.event_ms;
            end
            if (w_open && b.key_pos == w_key && b.is_tap_hold_key) begin
               if (b.edge_flag && b.taps_settled == 4'd0) begin
                  if (!w_retro) begin
                     if ((w_opts & OPT_RETRO) != 3'd0 && !w_cancelled) w_retro = 1'b1;
                     else close_window();
                  end
               end else if (b.edge_flag || w_retro) begin
                  close_window();
               end
            end
         end
         CMD_TICK: begin
            if (b.edge_flag) begin
               if (!(w_open && b.key_pos == w_key && !w_retro)) begin
                  if (w_open) close_window();
                  opts = '0;
                  if (csr_shadow.hokp)  opts |= OPT_HOKP;
                  if (csr_shadow.ph)    opts |= OPT_PH;
                  if (csr_shadow.retro) opts |= OPT_RETRO;
                  if (opts != 3'd0) begin
                     w_open = 1'b1;
                     w_retro = 1'b0;
                     w_key = b.key_pos;
                     w_stamp = b.event_ms;
                     w_opts = opts;
                     w_cancelled = 1'b0;
                     snap_press = peer_rec.presses;
                     snap_release = peer_rec.releases;
                  end
               end
            end else if (w_open && !w_retro) begin
               close_window();
            end
         end
         CMD_JUDGE: begin
            if (w_open && !w_retro && peer_press_seen() &&
                !(b.edge_flag && later_than(peer_rec.press_stamp, b.event_ms))) begin
               if ((w_opts & OPT_HOKP) != 3'd0) begin
                  settle = 1'b1;
               end else if ((w_opts & OPT_PH) != 3'd0 && peer_release_seen() &&
                            !(b.edge_flag &&
                              later_than(peer_rec.release_stamp, b.event_ms))) begin
                  settle = 1'b1;
               end
               if ((w_opts & OPT_RETRO) != 3'd0 && !w_cancelled) begin
                  w_cancelled = 1'b1;
                  cancel = 1'b1;
               end
            end
         end
         CMD_PEER: begin
            img.window        = b.peer_window_flag;
            img.presses       = b.peer_presses;
            img.releases      = b.peer_releases;
            img.press_stamp   = b.peer_press_stamp;
            img.release_stamp = b.peer_release_stamp;
            // a redelivered image is dropped
            if (!(peer_seen && peer_rec == img)) begin
               peer_rec = img;
               peer_seen = 1'b1;
               if (w_open) begin
                  if (!not_before(peer_rec.press_stamp, w_stamp))
                     snap_press = peer_rec.presses;
                  if (!not_before(peer_rec.release_stamp, w_stamp))
                     snap_release = peer_rec.releases;
               end
               if (w_open && w_retro && (w_opts & OPT_RETRO) != 3'd0 && !w_cancelled &&
                   peer_press_seen()) begin
                  w_cancelled = 1'b1;
                  cancel = 1'b1;
               end
            end
         end
         CMD_RELATION_RESET: begin
            peer_seen = 1'b0;
            peer_rec = '0;
            adv_rec = '0;
         end
         default: ;
      endcase
      if (b.cmd <= CMD_RELATION_RESET) changed = publish_adv();
      r.hold_settled      = settle;
      r.retro_cancel      = cancel;
      r.adv_changed       = changed;
      r.adv_window        = adv_rec.window;
      r.adv_presses       = adv_rec.presses;
      r.adv_releases      = adv_rec.releases;
      r.adv_press_stamp   = adv_rec.press_stamp;
      r.adv_release_stamp = adv_rec.release_stamp;
      return r;
   endfunction

   // ---------------------------------------------------------------- driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) expected_reports.push_back(judge_event(req_beat));
         if (!req_valid || !req_stall) begin
            if (pending_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_beat <= pending_events.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor
   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_beat_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               $display("%0t: unexpected report beat expected none actual %h",
                        $time, rsp_beat);
               errors++;
            end else begin
               want = expected_reports.pop_front();
               compare_field("hold_settled", 32'(want.hold_settled),
                             32'(rsp_beat.hold_settled));
               compare_field("retro_cancel", 32'(want.retro_cancel),
                             32'(rsp_beat.retro_cancel));
               compare_field("adv_changed", 32'(want.adv_changed),
                             32'(rsp_beat.adv_changed));
               compare_field("adv_window", 32'(want.adv_window), 32'(rsp_beat.adv_window));
               compare_field("adv_presses", 32'(want.adv_presses),
                             32'(rsp_beat.adv_presses));
               compare_field("adv_releases", 32'(want.adv_releases),
                             32'(rsp_beat.adv_releases));
               compare_field("adv_press_stamp", want.adv_press_stamp,
                             rsp_beat.adv_press_stamp);
               compare_field("adv_release_stamp", want.adv_release_stamp,
                             rsp_beat.adv_release_stamp);
            end
         end
         if (hold_off_left > 0) begin
            hold_off_left <= hold_off_left - 1;
            rsp_stall <= 1'b1;
            if (hold_off_left == 1) hold_off_done <= 1'b1;
         end else if (want_hold_off && !hold_off_done) begin
            hold_off_left <= HOLD_OFF_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   function automatic req_beat_type mk_beat(logic [2:0] c, logic f, logic [15:0] k,
                                            logic [31:0] ms, logic th, logic [3:0] taps);
      logic [159:0] noise;
      req_beat_type b;
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
      b = noise[$bits(req_beat_type)-1:0];
      b.cmd = c;
      b.edge_flag = f;
      b.key_pos = k;
      b.event_ms = ms;
      b.is_tap_hold_key = th;
      b.taps_settled = taps;
      return b;
   endfunction

   task automatic push_event(logic [2:0] c, logic f, logic [15:0] k, logic [31:0] ms,
                             logic th, logic [3:0] taps);
      pending_events.push_back(mk_beat(c, f, k, ms, th, taps));
   endtask

   task automatic push_peer(act_rec_type img);
      req_beat_type b;
      b = mk_beat(CMD_PEER, 1'($urandom), 16'($urandom), $urandom, 1'($urandom),
                  4'($urandom));
      b.peer_window_flag   = img.window;
      b.peer_presses       = img.presses;
      b.peer_releases      = img.releases;
      b.peer_press_stamp   = img.press_stamp;
      b.peer_release_stamp = img.release_stamp;
      pending_events.push_back(b);
   endtask

   function automatic logic [31:0] near_now();
      return gen_ms + 32'($urandom_range(0, 60)) - 32'd30;
   endfunction

   function automatic logic [15:0] pick_key();
      if ($urandom_range(0, 3) == 0) return 16'($urandom);
      return {8'($urandom_range(0, 3)), 8'($urandom_range(0, 5))};
   endfunction

   task automatic push_peer_step();
      case ($urandom_range(0, 7))
         0, 1, 2: begin
            gen_peer.presses = gen_peer.presses + 8'd1;
            gen_peer.press_stamp = near_now();
         end
         3, 4: begin
            gen_peer.releases = gen_peer.releases + 8'd1;
            gen_peer.release_stamp = near_now();
         end
         5: gen_peer.window = ($urandom_range(0, 3) != 0);
         6: ;  // resend unchanged
         default: begin
            gen_peer.presses = 8'($urandom);
            gen_peer.press_stamp = $urandom;
            gen_peer.release_stamp = $urandom;
         end
      endcase
      push_peer(gen_peer);
   endtask

   // one tapping-key episode: open a window, then mixed peer and local activity
   task automatic push_sequence();
      logic [15:0] key, other;
      logic th;
      int steps;
      key = pick_key();
      other = pick_key();
      th = ($urandom_range(0, 5) != 0);
      gen_ms = gen_ms + 32'($urandom_range(1, 50));
      push_event(CMD_TICK, 1'b1, key, gen_ms, th, 4'($urandom));
      steps = $urandom_range(3, 10);
      repeat (steps) begin
         gen_ms = gen_ms + 32'($urandom_range(0, 40));
         case ($urandom_range(0, 9))
            0, 1, 2: push_peer_step();
            3, 4: push_event(CMD_JUDGE, 1'($urandom), key, near_now(), th, 4'($urandom));
            5: push_event(CMD_RECORD, 1'($urandom), other, gen_ms, 1'($urandom),
                          4'($urandom));
            6: push_event(CMD_RECORD, 1'($urandom), key, gen_ms, th,
                          ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'd0);
            7: push_event(CMD_TICK, 1'($urandom), $urandom_range(0, 1) ? key : other,
                          gen_ms, th, 4'($urandom));
            8: push_peer(gen_peer);
            default: begin
               if ($urandom_range(0, 2) == 0)
                  push_event(CMD_RELATION_RESET, 1'($urandom), key, gen_ms, th, 4'd0);
               else
                  push_peer_step();
            end
         endcase
      end
      if ($urandom_range(0, 1)) push_event(CMD_RECORD, 1'b0, key, gen_ms, th, 4'd0);
   endtask

   task automatic push_noise();
      logic [2:0] c;
      if ($urandom_range(0, 19) == 0)
         c = 3'($urandom_range(CMD_UNKNOWN_FIRST, CMD_UNKNOWN_LAST));
      else
         c = 3'($urandom_range(CMD_RECORD, CMD_RELATION_RESET));
      push_event(c, 1'($urandom), 16'($urandom), $urandom, 1'($urandom), 4'($urandom));
   endtask

   // wait for every queued beat to be taken and answered, then let the pipe settle
   task automatic drain();
      do @(negedge clock);
      while (pending_events.size() != 0 || req_valid || expected_reports.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic val);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {31'd0, val};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_HOKP:  csr_shadow.hokp = val;
         REG_PH:    csr_shadow.ph = val;
         REG_RETRO: csr_shadow.retro = val;
         default: ;
      endcase
   endtask

   task automatic write_options(cfg_type setting);
      csr_write(REG_HOKP, setting.hokp);
      csr_write(REG_PH, setting.ph);
      csr_write(REG_RETRO, setting.retro);
   endtask

   initial begin
      cfg_type setting;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset options: no window can open
      push_event(CMD_UNKNOWN_LAST, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 4'hF);
      push_event(CMD_TICK, 1'b1, 16'h0102, 32'd100, 1'b1, 4'd0);
      push_event(CMD_RECORD, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 4'hF);
      push_event(CMD_RECORD, 1'b0, 16'h0000, 32'h0000_0000, 1'b0, 4'd0);
      drain();

      // permissive hold with retro tap
      write_options(cfg_type'(3'b011));
      push_peer(act_rec_type'{1'b1, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'h0});
      push_peer(act_rec_type'{1'b1, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'h0});
      push_event(CMD_TICK, 1'b1, 16'h0203, 32'd1000, 1'b1, 4'd0);
      push_peer(act_rec_type'{1'b1, 8'h00, 8'hFF, 32'd1005, 32'd0});
      push_event(CMD_JUDGE, 1'b1, 16'h0203, 32'd1003, 1'b1, 4'd0);
      push_event(CMD_JUDGE, 1'b0, 16'h0203, 32'd1003, 1'b1, 4'd0);
      push_peer(act_rec_type'{1'b1, 8'h00, 8'h00, 32'd1005, 32'd1010});
      push_event(CMD_JUDGE, 1'b1, 16'h0203, 32'd1008, 1'b1, 4'd0);
      push_event(CMD_JUDGE, 1'b0, 16'h0203, 32'd1008, 1'b1, 4'd0);
      push_event(CMD_RECORD, 1'b1, 16'h0203, 32'd1012, 1'b1, 4'd0);
      push_event(CMD_TICK, 1'b1, 16'h0203, 32'd1020, 1'b1, 4'd0);
      push_event(CMD_TICK, 1'b1, 16'h0203, 32'd1021, 1'b1, 4'd0);
      push_event(CMD_RECORD, 1'b1, 16'h0203, 32'd1025, 1'b1, 4'd0);
      push_event(CMD_JUDGE, 1'b0, 16'h0203, 32'd1026, 1'b1, 4'd0);
      push_peer(act_rec_type'{1'b1, 8'h01, 8'h00, 32'd1030, 32'd1010});
      push_event(CMD_RECORD, 1'b0, 16'h0203, 32'd1040, 1'b1, 4'd3);
      push_event(CMD_TICK, 1'b1, 16'hFFFF, 32'hFFFF_FFF0, 1'b1, 4'd0);
      push_event(CMD_TICK, 1'b0, 16'hFFFF, 32'h0000_0010, 1'b1, 4'd0);
      push_event(CMD_RECORD, 1'b1, 16'h0000, 32'd1050, 1'b0, 4'hF);
      push_event(CMD_RELATION_RESET, 1'b0, 16'h0000, 32'd1060, 1'b0, 4'd0);
      push_event(CMD_UNKNOWN_FIRST, 1'b0, 16'h0000, 32'd0, 1'b0, 4'd0);
      drain();

      for (int p = 0; p < 8; p++) begin
         setting = cfg_type'(3'(p ^ 7));
         write_options(setting);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
            default: begin send_idle_pct = 7; recv_stall_pct = 7; end
         endcase
         if (p == 0) want_hold_off = 1'b1;
         case ($urandom_range(0, 3))
            0: gen_ms = $urandom;
            1: gen_ms = 32'hFFFF_FF00;
            2: gen_ms = 32'h7FFF_FF80;
            default: gen_ms = 32'd0;
         endcase
         gen_peer.window = 1'b1;
         while (pending_events.size() < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) < 8) push_sequence();
            else push_noise();
         end
         drain();
      end

      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
